@@ rtl/core/text_console_writer_assert.svh @@
// Assertion helpers for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS_DEF    = 80;
  localparam int ROWS_DEF       = 25;
  localparam int TAB_SPACES_DEF = 4;

  localparam int CURSOR_POS_W = 11;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;

  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] PRINT_LAST   = 8'h7F;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] TAB_CODE     = 8'h09;

  localparam logic [3:0] TEXT_COLOR_RESET  = 4'h7;
  localparam logic [7:0] BLANK_COLOR_RESET = 8'h07;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_COLOR = 1'b1;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] SWP_FILL_ALL  = 2'd0;
  localparam logic [1:0] SWP_COPY_UP   = 2'd1;
  localparam logic [1:0] SWP_FILL_LAST = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } in_word_t;

  typedef struct packed {
    logic [CURSOR_POS_W-1:0] cursor_position;
    logic [7:0]              cell_char;
    logic [7:0]              cell_color;
  } out_word_t;

  typedef struct packed {
    logic [7:0] color;
    logic [7:0] char_code;
  } cell_t;

  typedef struct packed {
    logic       go;
    logic [1:0] mode;
  } sweep_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/tcw_cell_ram.sv @@
`default_nettype none
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire tcw_pkg::cell_t  wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output tcw_pkg::cell_t       rd_data
);
  import tcw_pkg::*;

  cell_t mem [DEPTH];
  cell_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ rtl/core/tcw_sweep.sv @@
`default_nettype none
module tcw_sweep #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tcw_pkg::sweep_ctl_t ctl,
  output tcw_pkg::sweep_sts_t      sts,
  input  wire tcw_pkg::cell_t      blank_cell,
  input  wire tcw_pkg::cell_t      rd_data,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output tcw_pkg::cell_t           wr_data,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr
);
  import tcw_pkg::*;

  localparam logic [AW-1:0] LAST_ALL       = AW'(ROWS * COLUMNS - 1);
  localparam logic [AW-1:0] COPY_LAST      = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ROW_FIRST = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] ROW_STEP       = AW'(COLUMNS);

  logic          run_r, run_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic          copying;
  logic          at_end;

  always_comb begin
    copying = run_r && (mode_r == SWP_COPY_UP);
    at_end  = (mode_r == SWP_COPY_UP) ? (idx_r == COPY_LAST) : (idx_r == LAST_ALL);

    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = blank_cell;
    if (pend_r) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr_r;
      wr_data = rd_data;
    end else if (run_r && !copying) begin
      wr_en = 1'b1;
    end

    rd_en   = copying;
    rd_addr = idx_r + ROW_STEP;

    sts.busy = run_r || pend_r;
    sts.done = (run_r && !copying && at_end) || (pend_r && !run_r);

    run_nxt       = run_r && !at_end;
    mode_nxt      = mode_r;
    idx_nxt       = idx_r + AW'(1);
    pend_nxt      = copying;
    pend_addr_nxt = idx_r;
    if (ctl.go) begin
      run_nxt  = 1'b1;
      mode_nxt = ctl.mode;
      idx_nxt  = (ctl.mode == SWP_FILL_LAST) ? LAST_ROW_FIRST : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      mode_r <= SWP_FILL_ALL;
      pend_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/text_console_writer.sv @@
`default_nettype none
// Text console writer: a ROWS x COLUMNS cell store with a cursor. Raise start with an
// input word while busy is low; every accepted word yields exactly one result word on
// out_word, marked by out_strobe for a single cycle, and the receiver cannot stall it.
// A printable, newline or ignored put and an in-range read raise busy while they run;
// an out-of-range read and an unused action are answered without raising busy, and a
// tab puts TAB_SPACES spaces. A put that must scroll first has the sweep unit move the
// rows up and then blank the last row. A clear blanks every cell. The cell memory has
// a single write port, which the sweep unit walks one cell per cycle. After reset the
// same unit fills the store with blanks, with busy high; configuration writes are taken
// meanwhile.
module text_console_writer #(
  parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS       = tcw_pkg::ROWS_DEF,
  parameter int TAB_SPACES = tcw_pkg::TAB_SPACES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire tcw_pkg::in_word_t                  in_word,
  output logic                                    out_strobe,
  output tcw_pkg::out_word_t                      out_word,
  input  wire logic                               cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcw_pkg::*;

  `include "text_console_writer_assert.svh"

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int POS_W = $clog2(CELLS + 1);
  localparam int ROW_W = $clog2(ROWS + 1);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int TAB_W = $clog2(TAB_SPACES + 1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_WIPE  = 3'd1;
  localparam logic [2:0] ST_IDLE  = 3'd2;
  localparam logic [2:0] ST_PUT   = 3'd3;
  localparam logic [2:0] ST_COPY  = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;
  localparam logic [2:0] ST_CLEAR = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             is_tab_r, is_tab_nxt;
  logic [TAB_W-1:0] tab_left_r, tab_left_nxt;
  logic [3:0]       text_color_r;
  logic [7:0]       blank_color_r;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;

  logic             finish;
  cell_t            cell_f;
  logic [7:0]       code;
  logic             accept;
  logic [POS_W-1:0] pos_chk;

  sweep_ctl_t       swp_ctl;
  sweep_sts_t       swp_sts;
  cell_t            blank_cell;
  logic             swp_wr_en, swp_rd_en;
  logic [AW-1:0]    swp_wr_addr, swp_rd_addr;
  cell_t            swp_wr_data;

  logic             cw_en, cr_en;
  logic [AW-1:0]    cw_addr, cr_addr;
  cell_t            cw_data;

  logic             ram_wr_en, ram_rd_en;
  logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
  cell_t            ram_wr_data, ram_rd_data;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    blank_cell.char_code = SPACE_CODE;
    blank_cell.color     = (state_r == ST_WIPE) ? BLANK_COLOR_RESET : blank_color_r;
  end

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    pos_nxt      = pos_r;
    char_nxt     = char_r;
    is_tab_nxt   = is_tab_r;
    tab_left_nxt = tab_left_r;
    swp_ctl      = '0;
    cw_en        = 1'b0;
    cw_addr      = AW'(pos_r);
    code         = is_tab_r ? SPACE_CODE : char_r;
    cw_data      = {4'h0, text_color_r, code};
    cr_en        = 1'b0;
    cr_addr      = AW'(in_word.read_row * COLUMNS + in_word.read_column);
    finish       = 1'b0;
    cell_f       = '0;

    case (state_r)
      ST_INIT: begin
        swp_ctl.go   = 1'b1;
        swp_ctl.mode = SWP_FILL_ALL;
        state_nxt    = ST_WIPE;
      end
      ST_WIPE: begin
        if (swp_sts.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_word.action)
            ACT_PUT: begin
              char_nxt     = in_word.char_code;
              is_tab_nxt   = (in_word.char_code == TAB_CODE);
              tab_left_nxt = (in_word.char_code == TAB_CODE) ? TAB_W'(TAB_SPACES) : TAB_W'(1);
              state_nxt    = ST_PUT;
            end
            ACT_READ: begin
              if ((32'(in_word.read_row) < ROWS) && (32'(in_word.read_column) < COLUMNS)) begin
                cr_en     = 1'b1;
                state_nxt = ST_READ;
              end else begin
                finish = 1'b1;
              end
            end
            ACT_CLEAR: begin
              swp_ctl.go   = 1'b1;
              swp_ctl.mode = SWP_FILL_ALL;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_PUT: begin
        if (row_r == ROW_W'(ROWS)) begin
          swp_ctl.go   = 1'b1;
          swp_ctl.mode = SWP_COPY_UP;
          state_nxt    = ST_COPY;
        end else begin
          if (code == NEWLINE_CODE) begin
            col_nxt = '0;
            row_nxt = row_r + ROW_W'(1);
            pos_nxt = pos_r - POS_W'(col_r) + POS_W'(COLUMNS);
          end else if (code inside {[SPACE_CODE:PRINT_LAST]}) begin
            cw_en   = 1'b1;
            pos_nxt = pos_r + POS_W'(1);
            if (col_r == COL_W'(COLUMNS - 1)) begin
              col_nxt = '0;
              row_nxt = row_r + ROW_W'(1);
            end else begin
              col_nxt = col_r + COL_W'(1);
            end
          end
          if (tab_left_r > TAB_W'(1)) begin
            tab_left_nxt = tab_left_r - TAB_W'(1);
          end else begin
            finish    = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_COPY: begin
        if (swp_sts.done) begin
          swp_ctl.go   = 1'b1;
          swp_ctl.mode = SWP_FILL_LAST;
          state_nxt    = ST_FILL;
        end
      end
      ST_FILL: begin
        if (swp_sts.done) begin
          row_nxt   = ROW_W'(ROWS - 1);
          pos_nxt   = pos_r - POS_W'(COLUMNS);
          state_nxt = ST_PUT;
        end
      end
      ST_READ: begin
        cell_f    = ram_rd_data;
        finish    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        if (swp_sts.done) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt                = finish;
    out_word_nxt.cursor_position = CURSOR_POS_W'(pos_nxt);
    out_word_nxt.cell_char       = cell_f.char_code;
    out_word_nxt.cell_color      = cell_f.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_r       <= '0;
      col_r       <= '0;
      pos_r       <= '0;
      tab_left_r  <= TAB_W'(1);
      is_tab_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      tab_left_r  <= tab_left_nxt;
      is_tab_r    <= is_tab_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    if (finish) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r  <= TEXT_COLOR_RESET;
      blank_color_r <= BLANK_COLOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEXT_COLOR:  text_color_r  <= cfg_data[3:0];
        REG_BLANK_COLOR: blank_color_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_strobe = out_valid_r;
  assign out_word   = out_word_r;

  always_comb begin
    ram_wr_en   = swp_wr_en || cw_en;
    ram_wr_addr = swp_wr_en ? swp_wr_addr : cw_addr;
    ram_wr_data = swp_wr_en ? swp_wr_data : cw_data;
    ram_rd_en   = swp_rd_en || cr_en;
    ram_rd_addr = swp_rd_en ? swp_rd_addr : cr_addr;
  end

  assign pos_chk = POS_W'(32'(row_r) * COLUMNS + 32'(col_r));

  tcw_sweep #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_sweep (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (swp_ctl),
    .sts        (swp_sts),
    .blank_cell (blank_cell),
    .rd_data    (ram_rd_data),
    .wr_en      (swp_wr_en),
    .wr_addr    (swp_wr_addr),
    .wr_data    (swp_wr_data),
    .rd_en      (swp_rd_en),
    .rd_addr    (swp_rd_addr)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  `TCW_ASSERT_NOW(a_idle_sweep_quiet, !busy, !swp_sts.busy, "sweep active while idle")
  `TCW_ASSERT_NOW(a_pos_tracks_cursor, 1'b1, pos_r == pos_chk, "cursor position out of step")
  `TCW_ASSERT_NEXT(a_accept_progress, accept, busy || out_strobe, "accepted word dropped")

endmodule
`default_nettype wire
